### hdl/ppsq_pkg.sv
`default_nettype none

package ppsq_pkg;

   // Field widths
   localparam int unsigned RANGE_W   = 16;
   localparam int unsigned ODO_W     = 32;
   localparam int unsigned HEAD_W    = 16;
   localparam int unsigned STEER_W   = 16;
   localparam int unsigned SPEED_W   = 4;
   localparam int unsigned PHASE_W   = 4;
   localparam int unsigned CARLEN_W  = 12;
   localparam int unsigned WAITCNT_W = 5;

   localparam logic [CARLEN_W-1:0]  CAR_LENGTH_RESET = 12'd500;
   localparam logic [WAITCNT_W-1:0] WAIT_TICKS       = 5'd30;

   // Headings in centidegrees
   localparam logic signed [17:0] HALF_TURN_CDEG = 18'sd18000;
   localparam logic signed [17:0] FULL_TURN_CDEG = 18'sd36000;
   localparam logic signed [17:0] HEAD_BRIGHT_DONE   = 18'sd4000;
   localparam logic signed [17:0] HEAD_BLEFT_DONE    = 18'sd500;
   localparam logic signed [17:0] HEAD_STRAIGHT_DONE = 18'sd50;

   localparam logic signed [STEER_W-1:0] LANE_LIMIT   = 16'sd10000;
   localparam logic signed [STEER_W-1:0] STEER_ZERO   = 16'sd0;
   localparam logic signed [STEER_W-1:0] STEER_RIGHT  = 16'sd436;
   localparam logic signed [STEER_W-1:0] STEER_LEFT   = -16'sd454;

   localparam logic signed [SPEED_W-1:0] SPEED_FAST    = 4'sd4;
   localparam logic signed [SPEED_W-1:0] SPEED_NORMAL  = 4'sd2;
   localparam logic signed [SPEED_W-1:0] SPEED_SLOW    = 4'sd1;
   localparam logic signed [SPEED_W-1:0] SPEED_STOP    = 4'sd0;
   localparam logic signed [SPEED_W-1:0] SPEED_REVERSE = -4'sd1;

   localparam logic [PHASE_W-1:0] PHASE_SCAN       = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_MEASURE    = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_ALIGN      = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_WAIT       = 4'd3;
   localparam logic [PHASE_W-1:0] PHASE_BRIGHT     = 4'd4;
   localparam logic [PHASE_W-1:0] PHASE_BSTRAIGHT  = 4'd5;
   localparam logic [PHASE_W-1:0] PHASE_BLEFT      = 4'd6;
   localparam logic [PHASE_W-1:0] PHASE_STRAIGHTEN = 4'd7;
   localparam logic [PHASE_W-1:0] PHASE_DONE       = 4'd8;

   typedef enum logic [8:0] {
      MODE_SCAN       = 9'b000000001,
      MODE_MEASURE    = 9'b000000010,
      MODE_ALIGN      = 9'b000000100,
      MODE_WAIT       = 9'b000001000,
      MODE_BRIGHT     = 9'b000010000,
      MODE_BSTRAIGHT  = 9'b000100000,
      MODE_BLEFT      = 9'b001000000,
      MODE_STRAIGHTEN = 9'b010000000,
      MODE_DONE       = 9'b100000000
   } mode_type;

   function automatic logic [PHASE_W-1:0] mode_to_phase(input mode_type mode);
      logic [PHASE_W-1:0] phase;
      phase = PHASE_DONE;
      unique case (mode)
         MODE_SCAN:       phase = PHASE_SCAN;
         MODE_MEASURE:    phase = PHASE_MEASURE;
         MODE_ALIGN:      phase = PHASE_ALIGN;
         MODE_WAIT:       phase = PHASE_WAIT;
         MODE_BRIGHT:     phase = PHASE_BRIGHT;
         MODE_BSTRAIGHT:  phase = PHASE_BSTRAIGHT;
         MODE_BLEFT:      phase = PHASE_BLEFT;
         MODE_STRAIGHTEN: phase = PHASE_STRAIGHTEN;
         default:         phase = PHASE_DONE;
      endcase
      return phase;
   endfunction

endpackage

`default_nettype wire

### hdl/parallel_parking_sequencer_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  four ranges, odometer, heading, lane steer
// rsp_      out        rsp_valid / rsp_stall  speed_code, steer_mrad, phase
// csr_      in         csr_wr_en              car_length (12 bit)
//
// Each beat is registered first in the input register and then in the result
// register; one beat per cycle is sustained while rsp_ does not stall; the sequencer
// state updates as the beat moves across, so consecutive ticks chain without gaps.
// A stall on rsp_ holds the result register and, through it, the input register;
// req_stall rises only when the input register is full and cannot advance.
// Synchronous active-high reset returns the sequencer to scanning, car length 500.

`default_nettype none

module parallel_parking_sequencer_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [ppsq_pkg::RANGE_W-1:0] req_ir_side_front,
   input  wire logic signed [ppsq_pkg::RANGE_W-1:0] req_ir_back,
   input  wire logic signed [ppsq_pkg::RANGE_W-1:0] req_us_ahead,
   input  wire logic signed [ppsq_pkg::RANGE_W-1:0] req_us_side_front,
   input  wire logic        [ppsq_pkg::ODO_W-1:0]   req_odometer_mm,
   input  wire logic signed [ppsq_pkg::HEAD_W-1:0]  req_heading_cdeg,
   input  wire logic signed [ppsq_pkg::STEER_W-1:0] req_lane_steer_mrad,
   // result channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic signed [ppsq_pkg::SPEED_W-1:0] rsp_speed_code,
   output      logic signed [ppsq_pkg::STEER_W-1:0] rsp_steer_mrad,
   output      logic        [ppsq_pkg::PHASE_W-1:0] rsp_phase,
   // configuration
   input  wire logic                                csr_wr_en,
   input  wire logic        [ppsq_pkg::CARLEN_W-1:0] csr_wr_data
);

   // ---------------------------------------------------------------
   // Handshake control
   // ---------------------------------------------------------------
   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;
   logic advance;

   // Advance a beat when the result register is empty or being drained.
   assign advance    = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = in_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;

   assign in_valid_in  = req_accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic signed [ppsq_pkg::RANGE_W-1:0] ir_front_ff, ir_rear_ff, us_ahead_ff, us_side_ff;
   logic        [ppsq_pkg::ODO_W-1:0]   odo_ff;
   logic signed [ppsq_pkg::HEAD_W-1:0]  heading_ff;
   logic signed [ppsq_pkg::STEER_W-1:0] lane_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ir_front_ff <= req_ir_side_front;
         ir_rear_ff  <= req_ir_back;
         us_ahead_ff <= req_us_ahead;
         us_side_ff  <= req_us_side_front;
         odo_ff      <= req_odometer_mm;
         heading_ff  <= req_heading_cdeg;
         lane_ff     <= req_lane_steer_mrad;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer state and configuration
   // ---------------------------------------------------------------
   ppsq_pkg::mode_type                    mode_ff, mode_in;
   logic [ppsq_pkg::WAITCNT_W-1:0]        wait_ticks_ff, wait_ticks_in;
   logic [ppsq_pkg::ODO_W-1:0]            path_mark_ff, path_mark_in;
   logic signed [ppsq_pkg::HEAD_W-1:0]    start_heading_ff, start_heading_in;
   logic [ppsq_pkg::CARLEN_W-1:0]         car_length_ff;

   // ---------------------------------------------------------------
   // Thresholds: constant multiples of car length by shift, subtract and add
   // ---------------------------------------------------------------
   logic [15:0] len_x15, len_x9, len_x6;
   logic [14:0] len_x2;

   assign len_x15 = {car_length_ff, 4'b0} - {4'b0, car_length_ff};
   assign len_x9  = {1'b0, car_length_ff, 3'b0} + {4'b0, car_length_ff};
   assign len_x6  = {2'b0, car_length_ff, 2'b0} + {3'b0, car_length_ff, 1'b0};
   assign len_x2  = {2'b0, car_length_ff, 1'b0};

   // Path since the mark, wrapping, times ten
   logic [ppsq_pkg::ODO_W-1:0] dpath;
   logic [ppsq_pkg::ODO_W+3:0] dpath_x10;

   assign dpath     = odo_ff - path_mark_ff;
   assign dpath_x10 = {1'b0, dpath, 3'b0} + {3'b0, dpath, 1'b0};

   logic path_ge_x15, path_gt_x9, path_gt_x6;
   assign path_ge_x15 = dpath_x10 >= {20'b0, len_x15};
   assign path_gt_x9  = dpath_x10 >  {20'b0, len_x9};
   assign path_gt_x6  = dpath_x10 >  {20'b0, len_x6};

   // ---------------------------------------------------------------
   // Range checks
   // ---------------------------------------------------------------
   logic        front_no_echo, side_clear, rear_pos, ahead_pos;
   logic [18:0] rear_x10;
   logic        rear_lt_tenth, rear_lt_half, ahead_lt_half;

   assign front_no_echo = ir_front_ff[15];
   assign side_clear    = us_side_ff[15] | (us_side_ff[14:0] > len_x2);
   assign rear_pos      = ~ir_rear_ff[15] & (ir_rear_ff != '0);
   assign ahead_pos     = ~us_ahead_ff[15] & (us_ahead_ff != '0);
   assign rear_x10      = {1'b0, ir_rear_ff[14:0], 3'b0} + {3'b0, ir_rear_ff[14:0], 1'b0};
   assign rear_lt_tenth = rear_pos & (rear_x10 < {7'b0, car_length_ff});
   assign rear_lt_half  = rear_pos & ({ir_rear_ff[14:0], 1'b0} < {4'b0, car_length_ff});
   assign ahead_lt_half = ahead_pos & ({us_ahead_ff[14:0], 1'b0} < {4'b0, car_length_ff});

   logic lane_wild;
   assign lane_wild = (lane_ff > ppsq_pkg::LANE_LIMIT) | (lane_ff < -ppsq_pkg::LANE_LIMIT);

   // ---------------------------------------------------------------
   // Heading difference, wrapped to a half turn either way
   // ---------------------------------------------------------------
   logic signed [16:0] hd_diff;
   logic        [16:0] hd_abs;
   logic signed [17:0] hd_abs_s, hd_diff_s, hd_wrap;

   assign hd_diff   = {heading_ff[15], heading_ff} - {start_heading_ff[15], start_heading_ff};
   assign hd_abs    = hd_diff[16] ? 17'(-hd_diff) : 17'(hd_diff);
   assign hd_abs_s  = $signed({1'b0, hd_abs});
   assign hd_diff_s = {hd_diff[16], hd_diff};

   always_comb begin
      if (hd_abs_s <= ppsq_pkg::HALF_TURN_CDEG) begin
         hd_wrap = hd_diff_s;
      end else if (hd_diff_s > 18'sd0) begin
         hd_wrap = hd_abs_s - ppsq_pkg::FULL_TURN_CDEG;
      end else begin
         hd_wrap = ppsq_pkg::FULL_TURN_CDEG - hd_abs_s;
      end
   end

   // ---------------------------------------------------------------
   // Mode transitions and command for the current tick
   // ---------------------------------------------------------------
   logic signed [ppsq_pkg::SPEED_W-1:0] speed_in;
   logic signed [ppsq_pkg::STEER_W-1:0] steer_in;
   logic [ppsq_pkg::WAITCNT_W-1:0]      wait_next;

   assign wait_next = wait_ticks_ff + 5'd1;

   always_comb begin
      mode_in          = mode_ff;
      wait_ticks_in    = wait_ticks_ff;
      path_mark_in     = path_mark_ff;
      start_heading_in = start_heading_ff;
      speed_in         = ppsq_pkg::SPEED_STOP;
      steer_in         = ppsq_pkg::STEER_ZERO;
      unique case (mode_ff)
         ppsq_pkg::MODE_SCAN: begin
            speed_in = ppsq_pkg::SPEED_FAST;
            steer_in = lane_ff;
            if (front_no_echo && side_clear) begin
               mode_in      = ppsq_pkg::MODE_MEASURE;
               path_mark_in = odo_ff;
            end
         end
         ppsq_pkg::MODE_MEASURE: begin
            speed_in = ppsq_pkg::SPEED_NORMAL;
            steer_in = lane_ff;
            if (path_ge_x15) begin
               mode_in      = ppsq_pkg::MODE_ALIGN;
               path_mark_in = odo_ff;
            end else if (!front_no_echo || lane_wild) begin
               mode_in = ppsq_pkg::MODE_SCAN;
            end
         end
         ppsq_pkg::MODE_ALIGN: begin
            speed_in = ppsq_pkg::SPEED_NORMAL;
            if (path_gt_x9) begin
               wait_ticks_in    = '0;
               mode_in          = ppsq_pkg::MODE_WAIT;
               start_heading_in = heading_ff;
            end
         end
         ppsq_pkg::MODE_WAIT: begin
            wait_ticks_in = wait_next;
            if (wait_next >= ppsq_pkg::WAIT_TICKS) begin
               mode_in      = ppsq_pkg::MODE_BRIGHT;
               path_mark_in = odo_ff;
            end
         end
         ppsq_pkg::MODE_BRIGHT: begin
            speed_in = ppsq_pkg::SPEED_REVERSE;
            steer_in = ppsq_pkg::STEER_RIGHT;
            if (hd_wrap > ppsq_pkg::HEAD_BRIGHT_DONE) begin
               mode_in      = ppsq_pkg::MODE_BSTRAIGHT;
               path_mark_in = odo_ff;
               steer_in     = ppsq_pkg::STEER_ZERO;
            end
            // obstacle close behind wins over the heading check
            if (rear_lt_tenth) begin
               mode_in      = ppsq_pkg::MODE_DONE;
               path_mark_in = odo_ff;
               speed_in     = ppsq_pkg::SPEED_STOP;
            end
         end
         ppsq_pkg::MODE_BSTRAIGHT: begin
            speed_in = ppsq_pkg::SPEED_REVERSE;
            if (path_gt_x6) begin
               mode_in      = ppsq_pkg::MODE_BLEFT;
               path_mark_in = odo_ff;
            end
         end
         ppsq_pkg::MODE_BLEFT: begin
            speed_in = ppsq_pkg::SPEED_REVERSE;
            steer_in = ppsq_pkg::STEER_LEFT;
            if ((hd_wrap < ppsq_pkg::HEAD_BLEFT_DONE) || rear_lt_half) begin
               mode_in = ppsq_pkg::MODE_STRAIGHTEN;
            end
         end
         ppsq_pkg::MODE_STRAIGHTEN: begin
            speed_in = ppsq_pkg::SPEED_SLOW;
            steer_in = ppsq_pkg::STEER_RIGHT;
            if (hd_wrap < ppsq_pkg::HEAD_STRAIGHT_DONE) begin
               mode_in = ppsq_pkg::MODE_DONE;
            end else if (ahead_lt_half) begin
               mode_in = ppsq_pkg::MODE_BLEFT;
            end
         end
         default: begin
            // done, and any unreachable code: stop and hold
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         mode_ff          <= ppsq_pkg::MODE_SCAN;
         wait_ticks_ff    <= '0;
         path_mark_ff     <= '0;
         start_heading_ff <= '0;
         car_length_ff    <= ppsq_pkg::CAR_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff          <= mode_in;
            wait_ticks_ff    <= wait_ticks_in;
            path_mark_ff     <= path_mark_in;
            start_heading_ff <= start_heading_in;
         end
         if (csr_wr_en) begin
            car_length_ff <= csr_wr_data;
         end
      end
   end

   // Result register: load on advance, hold while stalled
   logic signed [ppsq_pkg::SPEED_W-1:0] rsp_speed_ff;
   logic signed [ppsq_pkg::STEER_W-1:0] rsp_steer_ff;
   logic        [ppsq_pkg::PHASE_W-1:0] rsp_phase_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_speed_ff <= speed_in;
         rsp_steer_ff <= steer_in;
         rsp_phase_ff <= ppsq_pkg::mode_to_phase(mode_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_speed_code = rsp_speed_ff;
   assign rsp_steer_mrad = rsp_steer_ff;
   assign rsp_phase      = rsp_phase_ff;

`ifndef SYNTHESIS
   // A beat that advances is always presented on the next cycle
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid_ff)
      else $error("advanced beat not presented");

   // State moves only with a beat
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mode_ff) && $stable(path_mark_ff) && $stable(wait_ticks_ff)))
      else $error("sequencer state changed without a beat");

   // Done is final
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == ppsq_pkg::MODE_DONE) |=> (mode_ff == ppsq_pkg::MODE_DONE))
      else $error("left done mode");

   // The standstill counter never runs past its limit while waiting
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == ppsq_pkg::MODE_WAIT) |-> (wait_ticks_ff < ppsq_pkg::WAIT_TICKS))
      else $error("wait counter overran");
`endif

endmodule

`default_nettype wire
